/* rtl/core/ndvi_pkg.sv */
// ============================================================================
// ndvi_pkg: shared types, widths and helpers for the NDVI pixel masker
// Holds the fixed-point format, the status and register codes, the pipeline
// record types and the per-step functions of the quotient pipeline.
// ============================================================================
`timescale 1ns / 1ps

package ndvi_pkg;

  // Sample format: two's complement, two integer bits, the rest fraction.
  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = SAMPLE_BITS - 2;

  // Band sums and differences keep one extra bit so that nothing wraps.
  localparam int SUM_W = SAMPLE_BITS + 1;
  localparam int MAG_W = SAMPLE_BITS + 1;
  // Quotient magnitude below 2 * ONE needs FRAC_BITS + 1 bits.
  localparam int QUO_W = FRAC_BITS + 1;
  // Scaled dividend and partial remainder widths.
  localparam int NUM_W = 2 * SAMPLE_BITS;
  localparam int REM_W = NUM_W - QUO_W;

  // Quotient bits resolved in each divider stage.
  localparam int STEPS_PER_STAGE = 3;
  localparam int DIV_STAGES      = (QUO_W + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

  // Fixed-point one and the saturation limits.
  localparam logic [SAMPLE_BITS-1:0]        ONE_Q = SAMPLE_BITS'(1) << FRAC_BITS;
  localparam logic signed [SAMPLE_BITS-1:0] Q_MAX = ONE_Q;
  localparam logic signed [SAMPLE_BITS-1:0] Q_MIN = -ONE_Q;

  // Default water limit: -0.35 rounded to the nearest code.
  localparam longint ONE_L = longint'(1) << FRAC_BITS;
  localparam logic signed [SAMPLE_BITS-1:0] WATER_LIM_RST =
    SAMPLE_BITS'(-((64'sd35 * ONE_L + 64'sd50) / 64'sd100));

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NDWI_THR  = 2'd0,
    REG_WATER_LIM = 2'd1
  } cfg_reg_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_VALID    = 2'd0,
    ST_CLOUD    = 2'd1,
    ST_ZERO_DEN = 2'd2,
    ST_WATER    = 2'd3
  } status_t;

  // Per-pixel flags that ride along the pipeline.
  typedef struct packed {
    logic cloud;
    logic zden;
    logic wzero;
    logic last;
  } side_t;

  // Stage 1: band differences and sums.
  typedef struct packed {
    logic signed [SUM_W-1:0] d_v;
    logic signed [SUM_W-1:0] s_v;
    logic signed [SUM_W-1:0] d_w;
    logic signed [SUM_W-1:0] s_w;
    logic                    cloud;
    logic                    last;
  } sum_item_t;

  // Stage 2: magnitudes and quotient sign of one index.
  typedef struct packed {
    logic [MAG_W-1:0] ud;
    logic [MAG_W-1:0] us;
    logic             neg;
  } mag_lane_t;

  typedef struct packed {
    mag_lane_t v;
    mag_lane_t w;
    side_t     sd;
  } mag_item_t;

  // Divider lane state: divisor, partial remainder, dividend bits still to
  // shift in, quotient bits so far, sign and early saturation.
  typedef struct packed {
    logic [MAG_W-1:0] dvs;
    logic [REM_W-1:0] rem;
    logic [QUO_W-1:0] nlo;
    logic [QUO_W-1:0] quo;
    logic             neg;
    logic             sat;
  } div_lane_t;

  typedef struct packed {
    div_lane_t v;
    div_lane_t w;
    side_t     sd;
  } div_item_t;

  // Signed, saturated quotients.
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] ndvi;
    logic signed [SAMPLE_BITS-1:0] ndwi;
    side_t                         sd;
  } sgn_item_t;

  // One result.
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] ndvi;
    status_t                       status;
    logic                          last;
  } res_t;

  // Magnitude of a widened band sum or difference.
  function automatic logic [MAG_W-1:0] mag_of(logic signed [SUM_W-1:0] x);
    logic signed [SUM_W-1:0] nx;
    nx = -x;
    return x[SUM_W-1] ? MAG_W'(unsigned'(nx)) : MAG_W'(unsigned'(x));
  endfunction

  // Set up the divider: dividend is |d| * ONE + |s| / 2 for round-half-up.
  // A magnitude of at least twice the divisor always saturates.
  function automatic div_lane_t div_init(mag_lane_t m);
    logic [NUM_W-1:0] num;
    div_lane_t        r;
    num   = (NUM_W'(m.ud) << FRAC_BITS) + NUM_W'(m.us >> 1);
    r.dvs = m.us;
    r.rem = num[NUM_W-1:QUO_W];
    r.nlo = num[QUO_W-1:0];
    r.quo = '0;
    r.neg = m.neg;
    r.sat = ({1'b0, m.ud} >= {m.us, 1'b0});
    return r;
  endfunction

  // One restoring division step: resolves one quotient bit.
  function automatic div_lane_t div_step(div_lane_t a);
    logic [REM_W:0] sh;
    logic [REM_W:0] dv;
    logic [REM_W:0] diff;
    div_lane_t      r;
    r    = a;
    sh   = {a.rem, a.nlo[QUO_W-1]};
    dv   = (REM_W + 1)'(a.dvs);
    diff = sh - dv;
    r.nlo = {a.nlo[QUO_W-2:0], 1'b0};
    if (sh >= dv) begin
      r.rem = diff[REM_W-1:0];
      r.quo = {a.quo[QUO_W-2:0], 1'b1};
    end else begin
      r.rem = sh[REM_W-1:0];
      r.quo = {a.quo[QUO_W-2:0], 1'b0};
    end
    return r;
  endfunction

  // Clamp the quotient magnitude to ONE and apply the sign.
  function automatic logic signed [SAMPLE_BITS-1:0] finish_q(div_lane_t a);
    logic [SAMPLE_BITS-1:0] mag;
    if (a.sat || (a.quo > QUO_W'(ONE_Q))) begin
      mag = ONE_Q;
    end else begin
      mag = SAMPLE_BITS'(a.quo);
    end
    return a.neg ? signed'(-mag) : signed'(mag);
  endfunction

endpackage

/* rtl/core/ndvi_pixel_masker.sv */
// NDVI pixel masker. Takes one pixel request per clock while in_stall is low
// (red, near-infrared and green reflectances in signed Q1.14, a cloud flag
// and a last-pixel mark) and returns one result per pixel, in order: NDVI =
// (nir - red) / (red + nir) rounded to nearest and saturated to [-1, 1], plus
// a status of valid, cloud, zero denominator or water masked. A pixel is water
// masked when NDVI is below ndvi_water_limit and NDWI = (green - nir) /
// (green + nir) is below ndwi_threshold; a zero NDWI denominator never masks.
// Throughput is one pixel per clock while in_stall is low; the two 15-bit
// quotient pipelines resolve three quotient bits per stage.
// The output has a one-entry skid buffer, so in_stall is a registered signal.
// Configuration writes are always accepted (cfg_ready is tied high) and should
// be made while no pixels are in flight.
// ============================================================================
// ndvi_pixel_masker: pipelined NDVI / NDWI engine with water masking
// Ten-stage pipeline: band sums, magnitudes, divider setup, five divider
// stages, sign and clamp, then the status decision into the output register.
// ============================================================================
`timescale 1ns / 1ps

module ndvi_pixel_masker
  import ndvi_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  // Pixel input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_red,
  input  logic signed [SAMPLE_BITS-1:0] in_nir,
  input  logic signed [SAMPLE_BITS-1:0] in_green,
  input  logic                          in_cloud_flag,
  input  logic                          in_last_pixel,
  // Result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_ndvi,
  output logic [1:0]                    out_status,
  output logic                          out_last_pixel_out,
  // Configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [SAMPLE_BITS-1:0]        cfg_data
);

  // Configuration registers.
  logic signed [SAMPLE_BITS-1:0] thr_r;
  logic signed [SAMPLE_BITS-1:0] lim_r;

  // Pipeline stage registers and their valid bits.
  sum_item_t          s1_r;
  sum_item_t          s1_nxt;
  logic               s1_v_r;
  mag_item_t          s2_r;
  mag_item_t          s2_nxt;
  logic               s2_v_r;
  div_item_t          s3_nxt;
  div_item_t          div_r   [DIV_STAGES+1];
  div_item_t          div_nxt [DIV_STAGES];
  logic [DIV_STAGES:0] dv_r;
  sgn_item_t          sg_r;
  sgn_item_t          sg_nxt;
  logic               sg_v_r;
  res_t               res_nxt;

  // Output register and skid entry.
  res_t               out_res_r;
  logic               out_valid_r;
  res_t               skid_res_r;
  logic               skid_v_r;

  // The whole pipeline advances unless the skid entry is occupied.
  logic               en;

  assign en        = !skid_v_r;
  assign in_stall  = skid_v_r;
  assign cfg_ready = 1'b1;

  // Configuration register writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
      lim_r <= WATER_LIM_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_NDWI_THR:  thr_r <= signed'(cfg_data);
        REG_WATER_LIM: lim_r <= signed'(cfg_data);
        default: ;
      endcase
    end
  end

  // Stage 1: band differences and sums at full width.
  always_comb begin
    s1_nxt.d_v   = SUM_W'(in_nir) - SUM_W'(in_red);
    s1_nxt.s_v   = SUM_W'(in_red) + SUM_W'(in_nir);
    s1_nxt.d_w   = SUM_W'(in_green) - SUM_W'(in_nir);
    s1_nxt.s_w   = SUM_W'(in_green) + SUM_W'(in_nir);
    s1_nxt.cloud = in_cloud_flag;
    s1_nxt.last  = in_last_pixel;
  end

  // Stage 2: magnitudes, quotient signs and zero-denominator flags.
  always_comb begin
    s2_nxt.v.ud     = mag_of(s1_r.d_v);
    s2_nxt.v.us     = mag_of(s1_r.s_v);
    s2_nxt.v.neg    = s1_r.d_v[SUM_W-1] ^ s1_r.s_v[SUM_W-1];
    s2_nxt.w.ud     = mag_of(s1_r.d_w);
    s2_nxt.w.us     = mag_of(s1_r.s_w);
    s2_nxt.w.neg    = s1_r.d_w[SUM_W-1] ^ s1_r.s_w[SUM_W-1];
    s2_nxt.sd.cloud = s1_r.cloud;
    s2_nxt.sd.zden  = (s1_r.s_v == '0);
    s2_nxt.sd.wzero = (s1_r.s_w == '0);
    s2_nxt.sd.last  = s1_r.last;
  end

  // Stage 3: scaled dividends and early saturation.
  always_comb begin
    s3_nxt.v  = div_init(s2_r.v);
    s3_nxt.w  = div_init(s2_r.w);
    s3_nxt.sd = s2_r.sd;
  end

  // Divider stages: each resolves up to three quotient bits in both lanes.
  always_comb begin
    for (int g = 0; g < DIV_STAGES; g++) begin
      div_nxt[g] = div_r[g];
      for (int j = 0; j < STEPS_PER_STAGE; j++) begin
        if (g * STEPS_PER_STAGE + j < QUO_W) begin
          div_nxt[g].v = div_step(div_nxt[g].v);
          div_nxt[g].w = div_step(div_nxt[g].w);
        end
      end
    end
  end

  // Sign stage: clamp to one and restore the sign.
  always_comb begin
    sg_nxt.ndvi = finish_q(div_r[DIV_STAGES].v);
    sg_nxt.ndwi = finish_q(div_r[DIV_STAGES].w);
    sg_nxt.sd   = div_r[DIV_STAGES].sd;
  end

  // Status decision; NDVI is forced to zero unless the pixel is valid.
  always_comb begin
    res_nxt.last = sg_r.sd.last;
    res_nxt.ndvi = '0;
    if (sg_r.sd.cloud) begin
      res_nxt.status = ST_CLOUD;
    end else if (sg_r.sd.zden) begin
      res_nxt.status = ST_ZERO_DEN;
    end else if (!sg_r.sd.wzero && (sg_r.ndvi < lim_r) && (sg_r.ndwi < thr_r)) begin
      res_nxt.status = ST_WATER;
    end else begin
      res_nxt.status = ST_VALID;
      res_nxt.ndvi   = sg_r.ndvi;
    end
  end

  // Pipeline payload registers.
  always_ff @(posedge clk) begin
    if (en) begin
      s1_r     <= s1_nxt;
      s2_r     <= s2_nxt;
      div_r[0] <= s3_nxt;
      for (int g = 0; g < DIV_STAGES; g++) begin
        div_r[g+1] <= div_nxt[g];
      end
      sg_r     <= sg_nxt;
    end
  end

  // Pipeline valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      dv_r   <= '0;
      sg_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
      dv_r   <= {dv_r[DIV_STAGES-1:0], s2_v_r};
      sg_v_r <= dv_r[DIV_STAGES];
    end
  end

  // Output register and skid entry control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_v_r    <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      if (skid_v_r) begin
        out_valid_r <= 1'b1;
        skid_v_r    <= 1'b0;
      end else begin
        out_valid_r <= sg_v_r;
      end
    end else if (en && sg_v_r) begin
      skid_v_r <= 1'b1;
    end
  end

  // Output register and skid entry payload.
  always_ff @(posedge clk) begin
    if (!out_valid_r || !out_stall) begin
      if (skid_v_r) begin
        out_res_r <= skid_res_r;
      end else begin
        out_res_r <= res_nxt;
      end
    end else if (en && sg_v_r) begin
      skid_res_r <= res_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_ndvi           = out_res_r.ndvi;
  assign out_status         = out_res_r.status;
  assign out_last_pixel_out = out_res_r.last;

`ifndef SYNTHESIS
  // The skid entry only fills behind a held result.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_valid_r)
    else $error("skid entry holds a request while the output is empty");

  // The skid entry fills only when the output was stalled.
  a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(out_valid_r && out_stall))
    else $error("skid entry filled without an output stall");

  // Any status other than valid carries a zero NDVI.
  a_masked_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_VALID)) |-> (out_ndvi == '0))
    else $error("masked result carries a nonzero NDVI");

  // NDVI stays inside [-1, 1].
  a_ndvi_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_ndvi <= Q_MAX) && (out_ndvi >= Q_MIN)))
    else $error("NDVI outside the saturation range");
`endif

endmodule
